// ===== src/peb_pkg.sv =====
`default_nettype none

package peb_pkg;

  localparam int unsigned PRESSURE_W = 16;
  localparam int unsigned FLOW_W     = 24;
  // shared multiplier, A side: wide enough for the flow excess rate (-rate - deadband)
  localparam int unsigned MUL_A_W    = 34;

  // 0.5 cmH2O in 1/256 cmH2O units
  localparam logic signed [PRESSURE_W:0] PRESSURE_MARGIN = 17'sd128;
  localparam logic [7:0] LEVEL_MIN = 8'd20;
  localparam logic [7:0] LEVEL_MAX = 8'd255;

  localparam logic [2:0] REG_DRIVE_ENABLE   = 3'd0;
  localparam logic [2:0] REG_PRESSURE_GAIN  = 3'd1;
  localparam logic [2:0] REG_PRESSURE_DBAND = 3'd2;
  localparam logic [2:0] REG_FLOW_GAIN      = 3'd3;
  localparam logic [2:0] REG_FLOW_DBAND     = 3'd4;
  localparam logic [2:0] REG_LOW_FLOW_THR   = 3'd5;

  typedef struct packed {
    logic signed [PRESSURE_W-1:0] pressure_sample;
    logic signed [FLOW_W-1:0]     flow_sample;
    logic signed [PRESSURE_W-1:0] pressure_reference;
    logic [15:0]                  pid_drive;
  } peb_in_t;

  typedef struct packed {
    logic [7:0] blower_drive;
    logic       pressure_brake_active;
    logic       flow_brake_active;
  } peb_out_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_RATE_MUL,
    ST_FILT_LOAD,
    ST_FILT_DIV,
    ST_FILT_STORE,
    ST_BRAKE_MUL,
    ST_BRAKE_ACC,
    ST_DONE
  } peb_state_e;

  // one radix-16 digit of a divide by five; x = {remainder, next 4 bits} < 80
  function automatic logic [3:0] div5_digit(input logic [6:0] x);
    logic [3:0] d;
    d = '0;
    for (int k = 1; k < 16; k++) begin
      if (x >= 7'(5 * k)) begin
        d = 4'(k);
      end
    end
    return d;
  endfunction

endpackage

`default_nettype wire

// ===== src/peb_div5.sv =====
`default_nettype none

module peb_div5 #(
  parameter int unsigned W = 36
) (
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  wire logic         start_i,
  input  wire logic [W-1:0] dividend_i,
  output logic              done_o,
  output logic [W-1:0]      quotient_o
);

  localparam int unsigned ND   = (W + 3) / 4;
  localparam int unsigned PADW = ND * 4;
  localparam int unsigned CW   = $clog2(ND + 1);

  logic [PADW-1:0] sh_q;
  logic [PADW-1:0] quo_q;
  logic [2:0]      rem_q;
  logic [CW-1:0]   cnt_q;
  logic [6:0]      part;
  logic [3:0]      digit;

  assign part  = {rem_q, sh_q[PADW-1 -: 4]};
  assign digit = peb_pkg::div5_digit(part);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else if (start_i) begin
      cnt_q <= CW'(ND);
    end else if (cnt_q != '0) begin
      cnt_q <= cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      sh_q  <= PADW'(dividend_i);
      rem_q <= '0;
    end else if (cnt_q != '0) begin
      sh_q  <= sh_q << 4;
      rem_q <= 3'(part - 7'(digit) * 7'd5);
      quo_q <= {quo_q[PADW-5:0], digit};
    end
  end

  // high during the last digit step; quotient is valid the cycle after
  assign done_o     = (cnt_q == CW'(1));
  assign quotient_o = quo_q[W-1:0];

endmodule

`default_nettype wire

// ===== src/predictive_exhalation_brake.sv =====
`default_nettype none

// Predictive exhalation brake. Takes one control-tick word (pressure, flow, reference,
// PID drive) and returns one word with the blower compare value and two brake flags.
// One word is in flight at a time, and no new word is taken until the sequencer is back in
// idle. The two divide-by-five passes of the rate filters dominate; they run on a radix-16
// divider, four bits per cycle. Rate scaling and both brake terms share a single 34 x 16
// multiplier. A finished result sits in an output register, so a new word is accepted while
// it waits. The user must write APB registers only while no word is in flight; the block
// itself does not enforce this.
module predictive_exhalation_brake #(
  parameter int unsigned TICKS_PER_SECOND = 250
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              in_valid_i,
  output logic                   in_stall_o,
  input  wire peb_pkg::peb_in_t  in_data_i,
  output logic                   out_valid_o,
  input  wire logic              out_stall_i,
  output peb_pkg::peb_out_t      out_data_o,
  input  wire logic              psel,
  input  wire logic              penable,
  input  wire logic              pwrite,
  input  wire logic [4:0]        paddr,
  input  wire logic [31:0]       pwdata,
  output logic [31:0]            prdata,
  output logic                   pready
);

  localparam int unsigned TW = $clog2(TICKS_PER_SECOND + 1);
  localparam int unsigned BW = (TW + 1 > 16) ? TW + 1 : 16;
  localparam int unsigned AW = peb_pkg::MUL_A_W;
  localparam int unsigned PW = AW + BW;
  localparam int unsigned RW = peb_pkg::FLOW_W + 1 + TW;
  localparam int unsigned NW = ((RW > 34) ? RW : 34) + 2;
  localparam int unsigned DW = PW + 2;

  localparam logic signed [DW-1:0] DRIVE_LO = DW'(20 * 65536);
  localparam logic signed [DW-1:0] DRIVE_HI = DW'(256 * 65536);

  // configuration
  logic                      cfg_en_q;
  logic signed [15:0]        cfg_pgain_q;
  logic signed [15:0]        cfg_pdb_q;
  logic signed [15:0]        cfg_fgain_q;
  logic signed [15:0]        cfg_fdb_q;
  logic signed [23:0]        cfg_thr_q;
  logic                      cfg_wr;
  logic [2:0]                cfg_idx;

  // sequencer and datapath
  peb_pkg::peb_state_e       state_q, state_d;
  logic                      sel_q;
  peb_pkg::peb_in_t          in_q;
  logic signed [15:0]        prev_p_q;
  logic signed [23:0]        prev_f_q;
  logic signed [31:0]        filt_p_q;
  logic signed [31:0]        filt_f_q;
  logic signed [PW-1:0]      prod_q;
  logic signed [DW-1:0]      drive_q;
  logic                      neg_q;
  logic                      pflag_q;
  logic                      fflag_q;
  peb_pkg::peb_out_t         out_q;
  logic                      out_valid_q;

  logic                      in_acc;
  logic                      div_start;
  logic                      div_done;
  logic                      out_load;
  logic signed [16:0]        p_diff;
  logic signed [24:0]        f_diff;
  logic signed [16:0]        p_over;
  logic signed [AW-1:0]      pr_ex;
  logic signed [AW-1:0]      fr_ex;
  logic                      p_cond;
  logic                      p_hit;
  logic                      f_hit;
  logic signed [AW-1:0]      mul_a;
  logic signed [BW-1:0]      mul_b;
  logic signed [PW-1:0]      mul_p;
  logic signed [31:0]        filt_old;
  logic signed [NW-1:0]      m_val;
  logic [NW-1:0]             div_in;
  logic [NW-1:0]             div_quo;
  logic signed [NW-1:0]      q_val;
  logic signed [31:0]        q_sat;
  logic [7:0]                level;

  // ---------------- APB ----------------
  assign pready  = 1'b1;
  assign cfg_idx = paddr[4:2];
  assign cfg_wr  = psel && penable && pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_en_q    <= 1'b0;
      cfg_pgain_q <= 16'sd461;
      cfg_pdb_q   <= 16'sd128;
      cfg_fgain_q <= 16'sd0;
      cfg_fdb_q   <= 16'sd512;
      cfg_thr_q   <= 24'sd15360;
    end else if (cfg_wr) begin
      unique case (cfg_idx)
        peb_pkg::REG_DRIVE_ENABLE:   cfg_en_q    <= pwdata[0];
        peb_pkg::REG_PRESSURE_GAIN:  cfg_pgain_q <= pwdata[15:0];
        peb_pkg::REG_PRESSURE_DBAND: cfg_pdb_q   <= pwdata[15:0];
        peb_pkg::REG_FLOW_GAIN:      cfg_fgain_q <= pwdata[15:0];
        peb_pkg::REG_FLOW_DBAND:     cfg_fdb_q   <= pwdata[15:0];
        peb_pkg::REG_LOW_FLOW_THR:   cfg_thr_q   <= pwdata[23:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (cfg_idx)
      peb_pkg::REG_DRIVE_ENABLE:   prdata = {31'h0, cfg_en_q};
      peb_pkg::REG_PRESSURE_GAIN:  prdata = {16'h0, cfg_pgain_q};
      peb_pkg::REG_PRESSURE_DBAND: prdata = {16'h0, cfg_pdb_q};
      peb_pkg::REG_FLOW_GAIN:      prdata = {16'h0, cfg_fgain_q};
      peb_pkg::REG_FLOW_DBAND:     prdata = {16'h0, cfg_fdb_q};
      peb_pkg::REG_LOW_FLOW_THR:   prdata = {8'h0, cfg_thr_q};
      default:                     prdata = '0;
    endcase
  end

  // ---------------- datapath ----------------
  assign p_diff = 17'(in_q.pressure_sample) - 17'(prev_p_q);
  assign f_diff = 25'(in_q.flow_sample) - 25'(prev_f_q);
  assign p_over = 17'(in_q.pressure_sample) - 17'(in_q.pressure_reference);
  assign p_cond = p_over > peb_pkg::PRESSURE_MARGIN;

  assign pr_ex = AW'(filt_p_q) - AW'(cfg_pdb_q);
  assign fr_ex = -AW'(filt_f_q) - AW'(cfg_fdb_q);
  assign p_hit = p_cond && (pr_ex > AW'(0));
  // pressure above the reference by the margin, falling flow past the deadband, below the low-flow threshold
  assign f_hit = p_cond && (in_q.flow_sample < cfg_thr_q) && (fr_ex > AW'(0));

  always_comb begin
    if (state_q == peb_pkg::ST_RATE_MUL) begin
      mul_a = sel_q ? AW'(f_diff) : AW'(p_diff);
      mul_b = BW'(TICKS_PER_SECOND);
    end else begin
      mul_a = sel_q ? fr_ex : pr_ex;
      mul_b = sel_q ? BW'(cfg_fgain_q) : BW'(cfg_pgain_q);
    end
  end

  assign mul_p = mul_a * mul_b;

  // round(n/5) = floor((n+2)/5); negative values go through the ones' complement
  assign filt_old = sel_q ? filt_f_q : filt_p_q;
  assign m_val    = NW'($signed(prod_q[RW-1:0])) + (NW'(filt_old) <<< 2) + NW'(2);
  assign div_in   = m_val[NW-1] ? ~m_val : m_val;

  peb_div5 #(
    .W (NW)
  ) u_div5 (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (div_in),
    .done_o     (div_done),
    .quotient_o (div_quo)
  );

  assign q_val = neg_q ? $signed(~div_quo) : $signed(div_quo);

  always_comb begin
    if ((&q_val[NW-1:31]) || !(|q_val[NW-1:31])) begin
      q_sat = q_val[31:0];
    end else begin
      q_sat = q_val[NW-1] ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
    end
  end

  always_comb begin
    if (drive_q < DRIVE_LO) begin
      level = peb_pkg::LEVEL_MIN;
    end else if (drive_q >= DRIVE_HI) begin
      level = peb_pkg::LEVEL_MAX;
    end else begin
      level = drive_q[23:16];
    end
  end

  // ---------------- sequencer ----------------
  assign in_acc   = in_valid_i && !in_stall_o;
  assign in_stall_o = (state_q != peb_pkg::ST_IDLE);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= peb_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d   = state_q;
    div_start = 1'b0;
    out_load  = 1'b0;
    unique case (state_q)
      peb_pkg::ST_IDLE: begin
        if (in_valid_i) begin
          state_d = peb_pkg::ST_RATE_MUL;
        end
      end
      peb_pkg::ST_RATE_MUL:  state_d = peb_pkg::ST_FILT_LOAD;
      peb_pkg::ST_FILT_LOAD: begin
        div_start = 1'b1;
        state_d   = peb_pkg::ST_FILT_DIV;
      end
      peb_pkg::ST_FILT_DIV: begin
        if (div_done) begin
          state_d = peb_pkg::ST_FILT_STORE;
        end
      end
      peb_pkg::ST_FILT_STORE: begin
        state_d = sel_q ? peb_pkg::ST_BRAKE_MUL : peb_pkg::ST_RATE_MUL;
      end
      peb_pkg::ST_BRAKE_MUL: state_d = peb_pkg::ST_BRAKE_ACC;
      peb_pkg::ST_BRAKE_ACC: begin
        state_d = sel_q ? peb_pkg::ST_DONE : peb_pkg::ST_BRAKE_MUL;
      end
      peb_pkg::ST_DONE: begin
        if (!out_valid_q || !out_stall_i) begin
          out_load = 1'b1;
          state_d  = peb_pkg::ST_IDLE;
        end
      end
      default: state_d = peb_pkg::ST_IDLE;
    endcase
  end

  // control and history state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sel_q       <= 1'b0;
      prev_p_q    <= '0;
      prev_f_q    <= '0;
      filt_p_q    <= '0;
      filt_f_q    <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (in_acc) begin
        sel_q <= 1'b0;
      end else if (state_q == peb_pkg::ST_FILT_STORE || state_q == peb_pkg::ST_BRAKE_ACC) begin
        sel_q <= ~sel_q;
      end
      if (state_q == peb_pkg::ST_RATE_MUL) begin
        if (sel_q) begin
          prev_f_q <= in_q.flow_sample;
        end else begin
          prev_p_q <= in_q.pressure_sample;
        end
      end
      if (state_q == peb_pkg::ST_FILT_STORE) begin
        if (sel_q) begin
          filt_f_q <= q_sat;
        end else begin
          filt_p_q <= q_sat;
        end
      end
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // per-word payload
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      in_q    <= in_data_i;
      drive_q <= DW'($signed({1'b0, in_data_i.pid_drive, 8'h00}));
      pflag_q <= 1'b0;
      fflag_q <= 1'b0;
    end
    if (state_q == peb_pkg::ST_RATE_MUL || state_q == peb_pkg::ST_BRAKE_MUL) begin
      prod_q <= mul_p;
    end
    if (state_q == peb_pkg::ST_FILT_LOAD) begin
      neg_q <= m_val[NW-1];
    end
    if (state_q == peb_pkg::ST_BRAKE_MUL) begin
      if (sel_q) begin
        fflag_q <= f_hit;
      end else begin
        pflag_q <= p_hit;
      end
    end
    if (state_q == peb_pkg::ST_BRAKE_ACC && (sel_q ? fflag_q : pflag_q)) begin
      drive_q <= drive_q - DW'(prod_q);
    end
    if (out_load) begin
      out_q.blower_drive          <= cfg_en_q ? level : 8'h00;
      out_q.pressure_brake_active <= pflag_q;
      out_q.flow_brake_active     <= fflag_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  // ---------------- checks ----------------
  a_div_done_in_div: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_done |-> state_q == peb_pkg::ST_FILT_DIV)
    else $error("divider finished outside the divide state");

  a_result_from_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q == peb_pkg::ST_DONE))
    else $error("result word appeared without a finished computation");

  a_done_free_reg: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == peb_pkg::ST_DONE && !out_valid_q) |=> state_q == peb_pkg::ST_IDLE)
    else $error("finished word held although the output register was free");

  a_drive_floor: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ($rose(out_valid_q) && out_q.blower_drive != 8'h00)
      |-> out_q.blower_drive >= peb_pkg::LEVEL_MIN)
    else $error("enabled blower drive below its floor");

endmodule

`default_nettype wire
